### rtl/psgs_pkg.sv
// shared types and constants of the granular pitch shifter
package psgs_pkg;

  localparam int unsigned RING_DEPTH_DEF = 8192;
  localparam logic [15:0] FADE_STEP_RST = 16'd105;
  localparam logic [15:0] MIN_GAP_RST = 16'd503;
  localparam logic [17:0] ONE_Q16 = 18'h10000;
  localparam logic [17:0] TWO_Q16 = 18'h20000;
  localparam logic [18:0] RATIO_MAX = 19'h40000;

  // configuration register indexes
  localparam logic REG_FADE_STEP = 1'b0;
  localparam logic REG_MIN_GAP = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_PERIOD,
    S_DIV_RATIO,
    S_WRITE,
    S_DECIDE,
    S_RS_RD0,
    S_RS_RD1,
    S_RS_RD0_W,
    S_RS_RD1_W,
    S_RS_TGT,
    S_RS_MOVE1,
    S_RS_MOVE2,
    S_RS_Q0,
    S_RS_Q1,
    S_RS_Q0_W,
    S_RS_Q1_W,
    S_RS_DIV,
    S_RS_DONE,
    S_HA_RD0,
    S_HA_RD1,
    S_HA_W,
    S_HB_RD0,
    S_HB_RD1,
    S_HB_W,
    S_MIX,
    S_OUT
  } state_t;

endpackage

### rtl/pitch_synchronous_granular_shifter.sv
// granular pitch shifter: top level with sequencer, shared divider, rings
//
// An item is accepted when idle, divides for the period and then for the ratio,
// is written to the rings and, when a head restarts, reads the stored phases,
// moves the head and may run a phase alignment divide before both heads are
// read and mixed and the result is offered. A shared restoring divider produces
// one quotient bit per cycle. A stalled result is held until it is taken.
// The two rings are single-port memories read one word per cycle. The block
// takes no new item until the current result has been taken. After reset both
// rings are cleared by a pass over every address before the first item.
module pitch_synchronous_granular_shifter #(
  parameter int unsigned RING_DEPTH = psgs_pkg::RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_in,
  input  logic        [23:0] in_inc,
  input  logic        [23:0] out_inc,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  input  logic               cfg_we,
  input  logic        [0:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 16;
  localparam logic [24:0] MIN_INC =
    25'((3 * 64'd16777216 + RING_DEPTH - 1) / RING_DEPTH);

  psgs_pkg::state_t state, state_next;

  // config
  logic [15:0] fade_step, min_phase_gap;
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_step <= psgs_pkg::FADE_STEP_RST;
      min_phase_gap <= psgs_pkg::MIN_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        psgs_pkg::REG_FADE_STEP: fade_step <= cfg_data;
        psgs_pkg::REG_MIN_GAP: min_phase_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  // rings
  logic signed [15:0] sample_ring [RING_DEPTH];
  logic [23:0] phase_ring [RING_DEPTH];
  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic signed [15:0] mem_wsample;
  logic [23:0] mem_wphase;
  logic signed [15:0] rd_sample;
  logic [23:0] rd_phase;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_ring[mem_addr] <= mem_wsample;
      phase_ring[mem_addr] <= mem_wphase;
    end
    rd_sample <= sample_ring[mem_addr];
    rd_phase <= phase_ring[mem_addr];
  end

  // clear pass counter
  logic [AW:0] clr_cnt;
  logic clearing;
  assign clearing = !clr_cnt[AW];
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + 1'b1;
  end

  // block state
  logic [AW-1:0] write_index;
  logic [PW-1:0] head_one_pos, head_two_pos;
  logic [23:0] input_phase;
  logic [17:0] fade_level;
  logic second_armed;

  // item registers
  logic signed [15:0] smp;
  logic [23:0] inc_raw, oinc;
  logic [24:0] inc_eff;
  logic [24:0] in_inc_eff;
  logic [40:0] period;
  logic [18:0] ratio;
  logic [16:0] ff;
  logic head_sel;
  logic signed [15:0] x0;
  logic [23:0] p0, q0;
  logic signed [16:0] va, vb;
  logic signed [16:0] res;
  logic [PW-1:0] rpos;
  logic lag_ideal_dummy;

  // low input frequency clamp of the incoming item
  assign in_inc_eff = ({1'b0, in_inc} < MIN_INC) ? MIN_INC : {1'b0, in_inc};

  // shared restoring divider: num/den, one quotient bit per cycle
  logic [40:0] dv_rem;
  logic [40:0] dv_num;
  logic [40:0] dv_quo;
  logic [24:0] dv_den;
  logic [5:0] dv_cnt;
  logic dv_start;
  logic [40:0] dv_start_num;
  logic [24:0] dv_start_den;
  logic dv_busy;
  logic [41:0] dv_trial;
  assign dv_trial = {dv_rem, dv_num[40]} - {17'd0, dv_den};
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (dv_start) begin
      dv_busy <= 1'b1;
      dv_num <= dv_start_num;
      dv_den <= dv_start_den;
      dv_rem <= '0;
      dv_quo <= '0;
      dv_cnt <= 6'd41;
    end else if (dv_busy) begin
      if (!dv_trial[41]) dv_rem <= dv_trial[40:0];
      else dv_rem <= {dv_rem[39:0], dv_num[40]};
      dv_quo <= {dv_quo[39:0], !dv_trial[41]};
      dv_num <= {dv_num[39:0], 1'b0};
      dv_cnt <= dv_cnt - 1'b1;
      if (dv_cnt == 6'd1) dv_busy <= 1'b0;
    end
  end

  // shared interpolation multiplier: d * frac, rounded
  logic signed [25:0] mul_d;
  logic [15:0] mul_f;
  logic signed [42:0] mul_p;
  logic signed [26:0] mul_r;
  assign mul_p = mul_d * $signed({1'b0, mul_f});
  assign mul_r = 27'((mul_p + 43'sd32768) >>> 16);

  // lag helpers
  function automatic logic [AW-1:0] lag_f(input logic [AW-1:0] wi, input logic [PW-1:0] p);
    lag_f = wi - p[PW-1:16];
  endfunction

  logic [PW-1:0] per_m, pos_fwd, pos_back;
  logic [41:0] ideal_full;
  logic [25:0] ideal;
  logic [23:0] target;
  logic [23:0] gap;
  logic [24:0] qdiff;
  logic rs_strict;

  assign per_m = PW'(period);
  assign pos_fwd = rpos + per_m;
  assign pos_back = rpos - per_m;
  assign ideal_full = rs_strict ? (42'(period) * 42'd3) : (42'(period) << 1);
  assign ideal = ideal_full[41:16];
  assign gap = (min_phase_gap == 16'd0) ? 24'd1 : {8'd0, min_phase_gap};
  assign qdiff = {1'b0, rd_phase} - {1'b0, q0};

  logic [PW-1:0] hpos;
  assign hpos = head_sel ? head_two_pos : head_one_pos;

  // mix
  logic signed [17:0] ffs, ffc;
  logic signed [36:0] mixsum;
  logic signed [20:0] mixr;
  assign ffs = $signed({1'b0, ff});
  assign ffc = 18'sd65536 - ffs;
  assign mixsum = 37'(ffs * va) + 37'(ffc * vb);
  assign mixr = 21'((mixsum + 37'sd32768) >>> 16);

  assign in_stall = (state != psgs_pkg::S_IDLE) || clearing;
  assign out_valid = (state == psgs_pkg::S_OUT);
  assign sample_out = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) state <= psgs_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    mem_addr = write_index;
    mem_we = 1'b0;
    mem_wsample = smp;
    mem_wphase = input_phase;
    dv_start = 1'b0;
    dv_start_num = 41'd1 << 40;
    dv_start_den = inc_eff;
    mul_d = '0;
    mul_f = '0;
    if (clearing) begin
      mem_addr = clr_cnt[AW-1:0];
      mem_we = 1'b1;
      mem_wsample = '0;
      mem_wphase = '0;
    end
    case (state)
      psgs_pkg::S_IDLE: begin
        if (in_valid && !clearing) begin
          dv_start = 1'b1;
          dv_start_den = in_inc_eff;
          state_next = psgs_pkg::S_DIV_PERIOD;
        end
      end
      psgs_pkg::S_DIV_PERIOD: begin
        if (!dv_busy) begin
          dv_start = 1'b1;
          dv_start_num = {1'b0, oinc, 16'd0};
          state_next = psgs_pkg::S_DIV_RATIO;
        end
      end
      psgs_pkg::S_DIV_RATIO: if (!dv_busy && dv_cnt == 6'd0) state_next = psgs_pkg::S_WRITE;
      psgs_pkg::S_WRITE: begin
        mem_we = 1'b1;
        state_next = psgs_pkg::S_DECIDE;
      end
      psgs_pkg::S_DECIDE: begin
        if (fade_level >= psgs_pkg::TWO_Q16) state_next = psgs_pkg::S_RS_RD0;
        else if (fade_level >= psgs_pkg::ONE_Q16 && second_armed)
          state_next = psgs_pkg::S_RS_RD0;
        else state_next = psgs_pkg::S_HA_RD0;
      end
      psgs_pkg::S_RS_RD0: begin
        mem_addr = rpos[PW-1:16];
        state_next = psgs_pkg::S_RS_RD1;
      end
      psgs_pkg::S_RS_RD1: begin
        mem_addr = rpos[PW-1:16] + 1'b1;
        state_next = psgs_pkg::S_RS_RD0_W;
      end
      psgs_pkg::S_RS_RD0_W: begin
        mem_addr = rpos[PW-1:16] + 1'b1;
        state_next = psgs_pkg::S_RS_TGT;
      end
      psgs_pkg::S_RS_TGT: begin
        mul_d = 26'($signed({2'b0, rd_phase}) - $signed({2'b0, p0}));
        mul_f = rpos[15:0];
        state_next = psgs_pkg::S_RS_MOVE1;
      end
      psgs_pkg::S_RS_MOVE1: state_next = psgs_pkg::S_RS_MOVE2;
      psgs_pkg::S_RS_MOVE2: state_next = psgs_pkg::S_RS_Q0;
      psgs_pkg::S_RS_Q0: begin
        mem_addr = rpos[PW-1:16];
        state_next = psgs_pkg::S_RS_Q1;
      end
      psgs_pkg::S_RS_Q1: begin
        mem_addr = rpos[PW-1:16] + 1'b1;
        state_next = psgs_pkg::S_RS_Q0_W;
      end
      psgs_pkg::S_RS_Q0_W: begin
        mem_addr = rpos[PW-1:16] + 1'b1;
        state_next = psgs_pkg::S_RS_Q1_W;
      end
      psgs_pkg::S_RS_Q1_W: begin
        if ((rs_strict ? (q0 >= target) : (q0 > target)) || rd_phase < target
            || qdiff < {1'b0, gap}) state_next = psgs_pkg::S_RS_DONE;
        else begin
          dv_start = 1'b1;
          dv_start_num = {1'b0, 16'd0, target - q0} << 16;
          dv_start_den = qdiff;
          state_next = psgs_pkg::S_RS_DIV;
        end
      end
      psgs_pkg::S_RS_DIV: if (!dv_busy && dv_cnt == 6'd0) state_next = psgs_pkg::S_RS_DONE;
      psgs_pkg::S_RS_DONE: state_next = psgs_pkg::S_HA_RD0;
      psgs_pkg::S_HA_RD0, psgs_pkg::S_HB_RD0: begin
        mem_addr = hpos[PW-1:16];
        state_next = (state == psgs_pkg::S_HA_RD0) ? psgs_pkg::S_HA_RD1 : psgs_pkg::S_HB_RD1;
      end
      psgs_pkg::S_HA_RD1, psgs_pkg::S_HB_RD1: begin
        mem_addr = hpos[PW-1:16] + 1'b1;
        state_next = (state == psgs_pkg::S_HA_RD1) ? psgs_pkg::S_HA_W : psgs_pkg::S_HB_W;
      end
      psgs_pkg::S_HA_W, psgs_pkg::S_HB_W: begin
        mul_d = 26'($signed(rd_sample) - $signed(x0));
        mul_f = hpos[15:0];
        state_next = (state == psgs_pkg::S_HA_W) ? psgs_pkg::S_HB_RD0 : psgs_pkg::S_MIX;
      end
      psgs_pkg::S_MIX: state_next = psgs_pkg::S_OUT;
      psgs_pkg::S_OUT: if (!out_stall) state_next = psgs_pkg::S_IDLE;
      default: state_next = psgs_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      head_one_pos <= '0;
      head_two_pos <= '0;
      input_phase <= '0;
      fade_level <= '0;
      second_armed <= 1'b1;
      period <= '0;
    end else begin
      case (state)
        psgs_pkg::S_IDLE: begin
          if (in_valid && !clearing) begin
            smp <= sample_in;
            inc_raw <= in_inc;
            oinc <= out_inc;
            inc_eff <= in_inc_eff;
            period <= '0;
          end
        end
        psgs_pkg::S_DIV_PERIOD:
          if (!dv_busy) period <= dv_quo;
        psgs_pkg::S_DIV_RATIO:
          if (!dv_busy && dv_cnt == 6'd0)
            ratio <= (dv_quo > 41'(psgs_pkg::RATIO_MAX)) ? psgs_pkg::RATIO_MAX : dv_quo[18:0];
        psgs_pkg::S_DECIDE: begin
          if (fade_level >= psgs_pkg::TWO_Q16) begin
            head_sel <= 1'b0;
            rs_strict <= 1'b0;
            rpos <= head_one_pos;
            second_armed <= 1'b1;
            fade_level <= '0;
            ff <= '0;
          end else if (fade_level >= psgs_pkg::ONE_Q16) begin
            ff <= 17'(psgs_pkg::TWO_Q16 - fade_level);
            head_sel <= second_armed;
            rs_strict <= 1'b1;
            rpos <= head_two_pos;
            second_armed <= 1'b0;
          end else begin
            ff <= fade_level[16:0];
            head_sel <= 1'b0;
          end
        end
        psgs_pkg::S_RS_RD1: p0 <= rd_phase;
        psgs_pkg::S_RS_TGT: target <= 24'($signed({1'b0, p0}) + 25'(mul_r));
        psgs_pkg::S_RS_MOVE1: begin
          if (26'(lag_f(write_index, rpos)) > ideal) begin
            rpos <= pos_fwd;
            head_sel <= head_sel;
            rs_strict <= rs_strict;
            lag_ideal_dummy <= 1'b1;
          end else begin
            rpos <= pos_back;
            lag_ideal_dummy <= 1'b0;
          end
        end
        psgs_pkg::S_RS_MOVE2: begin
          if (lag_ideal_dummy) begin
            if (26'(lag_f(write_index, rpos)) > ideal) rpos <= pos_fwd;
          end else begin
            if (26'(lag_f(write_index, rpos)) < ideal) rpos <= pos_back;
          end
        end
        psgs_pkg::S_RS_Q1: q0 <= rd_phase;
        psgs_pkg::S_RS_DIV:
          if (!dv_busy && dv_cnt == 6'd0)
            rpos <= {rpos[PW-1:16], 16'd0} + PW'(dv_quo[16:0]);
        psgs_pkg::S_RS_DONE: begin
          if (head_sel) head_two_pos <= rpos;
          else head_one_pos <= rpos;
          head_sel <= 1'b0;
        end
        psgs_pkg::S_HA_RD1: head_sel <= 1'b0;
        psgs_pkg::S_HA_W: begin
          va <= 17'($signed(x0) + mul_r);
          head_sel <= 1'b1;
        end
        psgs_pkg::S_HB_W: vb <= 17'($signed(x0) + mul_r);
        psgs_pkg::S_MIX: begin
          if (mixr > 21'sd32767) res <= 17'sd32767;
          else if (mixr < -21'sd32768) res <= -17'sd32768;
          else res <= 17'(mixr);
          fade_level <= fade_level + {2'b0, fade_step};
          input_phase <= input_phase + inc_raw;
          write_index <= write_index + 1'b1;
          head_one_pos <= head_one_pos + PW'(ratio);
          head_two_pos <= head_two_pos + PW'(ratio);
        end
        default: ;
      endcase
      if (state == psgs_pkg::S_HA_RD1 || state == psgs_pkg::S_HB_RD1) x0 <= rd_sample;
    end
  end

  // checks
  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid) else $error("result during clear pass");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");
  a_fade_bounded: assert property (@(posedge clk) disable iff (rst)
    state == psgs_pkg::S_MIX |-> ff <= 17'h10000) else $error("gain above one");

endmodule

### verif/pitch_synchronous_granular_shifter_tb.sv
// self-checking testbench of the granular pitch shifter: predictor, driver, monitor
`timescale 1ns / 100ps

module pitch_synchronous_granular_shifter_tb;

  localparam int unsigned DEPTH = psgs_pkg::RING_DEPTH_DEF;
  localparam longint POS_SPAN = longint'(DEPTH) << 16;
  localparam longint INC_FLOOR = (3 * 64'd16777216 + DEPTH - 1) / DEPTH;
  localparam int unsigned SETTLE_CYCLES = 400;

  typedef struct {
    logic signed [15:0] smp;
    logic        [23:0] iinc;
    logic        [23:0] oinc;
  } grain_item_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample_in;
  logic        [23:0] in_inc;
  logic        [23:0] out_inc;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] sample_out;
  logic               cfg_we;
  logic        [0:0]  cfg_index;
  logic        [15:0] cfg_data;

  pitch_synchronous_granular_shifter u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .in_inc     (in_inc),
    .out_inc    (out_inc),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic signed [15:0] smp_ring [DEPTH];
  logic        [23:0] phs_ring [DEPTH];
  int unsigned        wr_idx;
  longint             head_a;
  longint             head_b;
  logic        [23:0] run_phase;
  logic        [17:0] fade_acc;
  bit                 b_armed;
  logic        [15:0] fade_step_r;
  logic        [15:0] min_gap_r;

  grain_item_t        pending_q[$];
  logic signed [15:0] expected_q[$];
  int                 err_cnt;
  int                 accepted_cnt;
  logic               took_in;

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint lag_of(longint pos);
    return (longint'(wr_idx) + DEPTH - (pos >> 16)) % DEPTH;
  endfunction

  function automatic longint wrap_add(longint pos, longint d);
    return (pos + d % POS_SPAN) % POS_SPAN;
  endfunction

  function automatic longint wrap_sub(longint pos, longint d);
    return (pos + POS_SPAN - d % POS_SPAN) % POS_SPAN;
  endfunction

  // move a head by whole periods toward its lag, then align its phase
  function automatic longint regrain_head(longint pos, longint period, int mult, bit strict);
    longint idx, frac, p0, p1, tgt, ideal, q0, q1, diff, gap, nf;
    bit low_bad;
    idx = pos >> 16;
    frac = pos & 16'hFFFF;
    p0 = longint'(phs_ring[idx]);
    p1 = longint'(phs_ring[(idx + 1) % DEPTH]);
    tgt = p0 + rnd16((p1 - p0) * frac);
    ideal = (period * mult) >> 16;
    if (lag_of(pos) > ideal) begin
      pos = wrap_add(pos, period);
      if (lag_of(pos) > ideal) pos = wrap_add(pos, period);
    end else begin
      pos = wrap_sub(pos, period);
      if (lag_of(pos) < ideal) pos = wrap_sub(pos, period);
    end
    idx = pos >> 16;
    q0 = longint'(phs_ring[idx]);
    q1 = longint'(phs_ring[(idx + 1) % DEPTH]);
    diff = q1 - q0;
    gap = (min_gap_r != 0) ? longint'(min_gap_r) : 1;
    low_bad = strict ? (q0 >= tgt) : (q0 > tgt);
    if (!(low_bad || q1 < tgt || diff < gap)) begin
      nf = ((tgt - q0) << 16) / diff;
      pos = ((idx << 16) + nf) % POS_SPAN;
    end
    return pos;
  endfunction

  function automatic longint tap_head(longint pos);
    longint idx, frac, x0, x1;
    idx = pos >> 16;
    frac = pos & 16'hFFFF;
    x0 = longint'(smp_ring[idx]);
    x1 = longint'(smp_ring[(idx + 1) % DEPTH]);
    return x0 + rnd16((x1 - x0) * frac);
  endfunction

  // one item through the shifter, returns the crossfaded sample
  function automatic logic signed [15:0] shift_grain(grain_item_t it);
    longint inc_eff, period, ratio, ff, a, b, mix;
    inc_eff = (longint'(it.iinc) < INC_FLOOR) ? INC_FLOOR : longint'(it.iinc);
    period = (longint'(1) << 40) / inc_eff;
    ratio = (longint'(it.oinc) << 16) / inc_eff;
    if (ratio > longint'(psgs_pkg::RATIO_MAX)) ratio = longint'(psgs_pkg::RATIO_MAX);
    smp_ring[wr_idx] = it.smp;
    phs_ring[wr_idx] = run_phase;
    if (fade_acc >= psgs_pkg::TWO_Q16) begin
      head_a = regrain_head(head_a, period, 2, 1'b0);
      b_armed = 1'b1;
      fade_acc = '0;
      ff = 0;
    end else if (fade_acc >= psgs_pkg::ONE_Q16) begin
      if (b_armed) begin
        b_armed = 1'b0;
        head_b = regrain_head(head_b, period, 3, 1'b1);
      end
      ff = longint'(psgs_pkg::TWO_Q16) - longint'(fade_acc);
    end else begin
      ff = longint'(fade_acc);
    end
    a = tap_head(head_a);
    b = tap_head(head_b);
    mix = rnd16(ff * a + (65536 - ff) * b);
    if (mix > 32767) mix = 32767;
    if (mix < -32768) mix = -32768;
    fade_acc = fade_acc + fade_step_r;
    run_phase = run_phase + it.iinc;
    wr_idx = (wr_idx + 1) % DEPTH;
    head_a = wrap_add(head_a, ratio);
    head_b = wrap_add(head_b, ratio);
    return mix[15:0];
  endfunction

  // monitor: check results, predict accepted items
  always @(posedge clk) begin
    logic signed [15:0] want;
    took_in <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0d", $time, sample_out);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (sample_out !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(shift_grain('{sample_in, in_inc, out_inc}));
        accepted_cnt++;
      end
    end
  end

  // driver: bursts of items with random gaps
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    grain_item_t it;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst && (!in_valid || took_in)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        nxt_valid = 1'b1;
        sample_in <= it.smp;
        in_inc <= it.iinc;
        out_inc <= it.oinc;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // receiver: stall pattern by modes, plus one long hold-off
  int stall_pct;
  int mode_left;
  int hold_left;
  bit hold_done;
  always @(negedge clk) begin
    if (!hold_done && accepted_cnt >= 400) begin
      hold_done = 1'b1;
      hold_left = 3000;
    end
    if (mode_left <= 0) begin
      mode_left = $urandom_range(50, 400);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 50;
        default: stall_pct = 90;
      endcase
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_item(logic signed [15:0] s, logic [23:0] ii, logic [23:0] oi);
    grain_item_t it;
    it.smp = s;
    it.iinc = ii;
    it.oinc = oi;
    pending_q.push_back(it);
  endtask

  // a steady pitch segment with a wandering waveform, or loose noise
  task automatic push_segment(int n);
    logic [23:0] ii, oi;
    int lvl, stp, k;
    bit noisy;
    longint scaled;
    noisy = ($urandom_range(0, 4) == 0);
    ii = 24'($urandom_range(6200, 8388608));
    if ($urandom_range(0, 3) == 0) ii = 24'($urandom_range(6200, 200000));
    oi = 24'($urandom_range(0, 8388608));
    if ($urandom_range(0, 2) == 0) begin
      scaled = (longint'(ii) * $urandom_range(1, 400)) / 100;
      oi = (scaled > 8388608) ? 24'd8388608 : scaled[23:0];
    end
    lvl = $urandom_range(0, 65535) - 32768;
    stp = $urandom_range(1, 4000);
    for (k = 0; k < n; k++) begin
      if (noisy) begin
        push_item(16'($urandom_range(0, 65535)), 24'($urandom_range(6200, 8388608)),
                  24'($urandom_range(0, 8388608)));
      end else begin
        lvl += stp;
        if (lvl > 32767 || lvl < -32768) begin
          stp = -stp;
          lvl += 2 * stp;
        end
        push_item(lvl[15:0], ii, oi);
      end
    end
  endtask

  task automatic drain_all();
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == psgs_pkg::REG_FADE_STEP) fade_step_r = val;
    else min_gap_r = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [15:0] fs, logic [15:0] mg, int n);
    int done;
    write_reg(psgs_pkg::REG_FADE_STEP, fs);
    write_reg(psgs_pkg::REG_MIN_GAP, mg);
    done = 0;
    while (done < n) begin
      push_segment($urandom_range(20, 120));
      done = pending_q.size() + done;
      wait (pending_q.size() == 0);
      done = done;
    end
    drain_all();
  endtask

  // stimulus sequence
  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    in_inc = '0;
    out_inc = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    took_in = 1'b0;
    err_cnt = 0;
    accepted_cnt = 0;
    burst_left = 1;
    gap_left = 0;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_done = 1'b0;
    for (i = 0; i < DEPTH; i++) begin
      smp_ring[i] = '0;
      phs_ring[i] = '0;
    end
    wr_idx = 0;
    head_a = 0;
    head_b = 0;
    run_phase = '0;
    fade_acc = '0;
    b_armed = 1'b1;
    fade_step_r = psgs_pkg::FADE_STEP_RST;
    min_gap_r = psgs_pkg::MIN_GAP_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, saturated ratio, slow and fast pitch
    push_item(16'sh7FFF, 24'd6200, 24'd0);
    push_item(-16'sh8000, 24'd6200, 24'd8388608);
    push_item(16'sh7FFF, 24'd8388608, 24'd8388608);
    push_item(-16'sh8000, 24'd8388608, 24'd0);
    push_item(16'sh0000, 24'd100000, 24'd400000);
    push_item(16'sh5555, 24'd100000, 24'd500000);
    push_item(-16'sh2AAB, 24'hFFFF00 >> 1, 24'd12345);
    for (i = 0; i < 10; i++) push_item(i[0] ? 16'sh7FFF : -16'sh8000, 24'd50000, 24'd75000);
    drain_all();

    // fastest fade, smallest gap threshold
    random_phase(16'hFFFF, 16'd0, 300);
    // slowest fade, strictest threshold
    random_phase(16'd1, 16'hFFFF, 80);
    // fast restarts at default threshold
    random_phase(16'd3000, psgs_pkg::MIN_GAP_RST, 400);
    // random settings
    random_phase(16'($urandom_range(300, 9000)), 16'($urandom_range(0, 3000)), 450);
    random_phase(16'($urandom_range(9000, 40000)), 16'($urandom_range(0, 65535)), 450);

    if (err_cnt == 0) begin
      $display("[pitch_synchronous_granular_shifter] OK");
    end else begin
      $display("[pitch_synchronous_granular_shifter] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("[pitch_synchronous_granular_shifter] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/psgs_pkg.sv
rtl/pitch_synchronous_granular_shifter.sv
verif/pitch_synchronous_granular_shifter_tb.sv
